>>> sv/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

	localparam int HEAP_BYTES_DEF = 65536;
	localparam logic [16:0] EXTENT_RESET = 17'h10000;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FAIL = 1'b1;

	typedef enum logic [4:0] {
		ST_INIT_W0, ST_INIT_W1, ST_IDLE,
		ST_A_RS, ST_A_RN, ST_A_CHK, ST_A_WN4, ST_A_WN0, ST_A_LINK, ST_A_WF,
		ST_F_RS, ST_F_WS, ST_F_CMP, ST_F_RN, ST_F_WCHK, ST_F_WO, ST_F_WF,
		ST_F_M2, ST_F_WH,
		ST_M_RS, ST_M_RN, ST_M_CHK, ST_M_RNS, ST_M_RNN, ST_M_W4, ST_M_W0,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic        we;
		logic [31:0] addr;
		logic [31:0] wdata;
	} mem_req_t;

endpackage
`default_nettype wire

>>> sv/ffa_mem.sv
`default_nettype none
// Byte heap with a 32-bit little-endian access sequencer, one byte a cycle.
module ffa_mem #(
	parameter int HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire ffa_pkg::mem_req_t req,
	output logic                  busy,
	output logic                  done,
	output logic [31:0]           rdata
);
	localparam int AW = $clog2(HEAP_BYTES);

	logic [7:0]    mem [HEAP_BYTES];
	logic          active_q;
	logic          we_q;
	logic [31:0]   addr_q;
	logic [31:0]   wdata_q;
	logic [2:0]    ph_q;
	logic [7:0]    rd_byte_s1;
	logic [31:0]   rdata_q;
	logic [31:0]   byte_addr;
	logic [AW-1:0] idx;

	assign byte_addr = addr_q + {30'd0, ph_q[1:0]};
	assign idx       = byte_addr[AW-1:0];
	assign busy      = active_q;
	assign done      = active_q && ((we_q && ph_q == 3'd3) || (!we_q && ph_q == 3'd4));
	assign rdata     = {rd_byte_s1, rdata_q[31:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ph_q     <= 3'd0;
		end else if (start) begin
			active_q <= 1'b1;
			ph_q     <= 3'd0;
		end else if (done) begin
			active_q <= 1'b0;
		end else if (active_q) begin
			ph_q <= ph_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			we_q    <= req.we;
			addr_q  <= req.addr;
			wdata_q <= req.wdata;
		end
		if (active_q && !we_q && ph_q != 3'd0)
			rdata_q <= {rd_byte_s1, rdata_q[31:8]};
	end

	always_ff @(posedge clk) begin
		if (active_q && !ph_q[2]) begin
			if (we_q)
				mem[idx] <= wdata_q[ph_q[1:0]*8 +: 8];
			rd_byte_s1 <= mem[idx];
		end
	end

endmodule
`default_nettype wire

>>> sv/first_fit_heap_allocator_top.sv
`default_nettype none
// First-fit heap allocator. The free list lives in the heap memory itself.
// Request channel: req_valid/req_stall with opcode (allocate or free),
// request_bytes and block_address; a request is taken when req_valid is high
// and req_stall is low. Response channel: rsp_valid/rsp_stall with status
// and address, exactly one response per request, held while stalled.
// Configuration: cfg_we/cfg_wdata write heap_extent and rebuild the heap as
// one free node; write it only while the block is idle.
// Every 32-bit heap word passes the single byte port one byte at a time,
// plus a sequencing step per access. An allocate reads each free-list node
// examined, then splits the node where needed, links, coalesces and tags
// the block, absorbing adjacent nodes. A free reads and rewrites the size
// word, reads the next pointer of each node walked, then links the block in
// at the list head or elsewhere and absorbs adjacent nodes. One request is
// in flight at a time; req_stall stays high until the response is loaded
// into the output register.
// Reset: two word writes build the initial node, during which req_stall
// is high. A stalled response holds the output register; the sequencer
// waits in its response step until the register frees.
// HEAP_BYTES must be a power of two.
module first_fit_heap_allocator_top #(
	parameter int HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [16:0] cfg_wdata,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        opcode,
	input  wire logic [15:0] request_bytes,
	input  wire logic [15:0] block_address,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic             status,
	output logic [15:0]      address
);
	localparam int CAP_I = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
	localparam logic [16:0] CAP = CAP_I[16:0];

	ffa_pkg::state_t state_q, state_d, ret_q;
	ffa_pkg::mem_req_t mreq;

	logic [16:0] ext_q, ext_c;
	logic [16:0] limit_q;
	logic [16:0] k_q, mk_q;
	logic [31:0] head_q, f_q, prev_q, newf_q, fs_q, fn_q, size_q, off_q;
	logic [31:0] mf_q, s_q, n_q, ns_q, nn_q, merged;
	logic        op_q, has_prev_q, fail_q, pend_q, need;
	logic        mem_start, mem_busy, mem_done, step_done;
	logic [31:0] mem_rdata;
	logic [16:0] req_sz;
	logic        rsp_valid_q, status_q;
	logic [15:0] address_q;
	logic        accept, load_rsp;

	// Clamp the written extent to the legal range
	always_comb begin
		ext_c = ext_q;
		if (ext_q < 17'd16)
			ext_c = 17'd16;
		else if (ext_q > CAP)
			ext_c = CAP;
	end

	assign req_sz    = {1'b0, request_bytes} + 17'd4;
	assign merged    = s_q + ns_q + 32'd8;
	assign req_stall = (state_q != ffa_pkg::ST_IDLE) || cfg_we;
	assign accept    = req_valid && !req_stall;
	assign load_rsp  = (state_q == ffa_pkg::ST_RESP) && (!rsp_valid_q || !rsp_stall);
	assign mem_start = need && !pend_q && !mem_busy;
	assign step_done = need ? mem_done : 1'b1;

	// Memory request per step
	always_comb begin
		need       = 1'b1;
		mreq.we    = 1'b0;
		mreq.addr  = 32'd0;
		mreq.wdata = 32'd0;
		case (state_q)
			ffa_pkg::ST_INIT_W0: begin
				mreq.we = 1'b1; mreq.wdata = {15'd0, ext_c} - 32'd8;
			end
			ffa_pkg::ST_INIT_W1: begin
				mreq.we = 1'b1; mreq.addr = 32'd4;
			end
			ffa_pkg::ST_A_RS:  mreq.addr = f_q;
			ffa_pkg::ST_A_RN:  mreq.addr = f_q + 32'd4;
			ffa_pkg::ST_A_WN4: begin
				mreq.we = 1'b1; mreq.addr = newf_q + 32'd4; mreq.wdata = fn_q;
			end
			ffa_pkg::ST_A_WN0: begin
				mreq.we = 1'b1; mreq.addr = newf_q; mreq.wdata = fs_q - size_q;
			end
			ffa_pkg::ST_A_LINK: begin
				need = has_prev_q;
				mreq.we = 1'b1; mreq.addr = prev_q + 32'd4; mreq.wdata = newf_q;
			end
			ffa_pkg::ST_A_WF: begin
				mreq.we = 1'b1; mreq.addr = f_q; mreq.wdata = size_q;
			end
			ffa_pkg::ST_F_RS:  mreq.addr = off_q;
			ffa_pkg::ST_F_WS: begin
				mreq.we = 1'b1; mreq.addr = off_q; mreq.wdata = fs_q - 32'd8;
			end
			ffa_pkg::ST_F_RN:  mreq.addr = f_q + 32'd4;
			ffa_pkg::ST_F_WO: begin
				mreq.we = 1'b1; mreq.addr = off_q + 32'd4; mreq.wdata = fn_q;
			end
			ffa_pkg::ST_F_WF: begin
				mreq.we = 1'b1; mreq.addr = f_q + 32'd4; mreq.wdata = off_q;
			end
			ffa_pkg::ST_F_WH: begin
				mreq.we = 1'b1; mreq.addr = off_q + 32'd4; mreq.wdata = head_q;
			end
			ffa_pkg::ST_M_RS:  mreq.addr = mf_q;
			ffa_pkg::ST_M_RN:  mreq.addr = mf_q + 32'd4;
			ffa_pkg::ST_M_RNS: mreq.addr = n_q;
			ffa_pkg::ST_M_RNN: mreq.addr = n_q + 32'd4;
			ffa_pkg::ST_M_W4: begin
				mreq.we = 1'b1; mreq.addr = mf_q + 32'd4; mreq.wdata = nn_q;
			end
			ffa_pkg::ST_M_W0: begin
				mreq.we = 1'b1; mreq.addr = mf_q; mreq.wdata = merged;
			end
			default: need = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffa_pkg::ST_INIT_W0: if (step_done) state_d = ffa_pkg::ST_INIT_W1;
			ffa_pkg::ST_INIT_W1: if (step_done) state_d = ffa_pkg::ST_IDLE;
			ffa_pkg::ST_IDLE: begin
				if (cfg_we)
					state_d = ffa_pkg::ST_INIT_W0;
				else if (accept)
					state_d = (opcode == ffa_pkg::OP_ALLOC) ? ffa_pkg::ST_A_RS
						: ffa_pkg::ST_F_RS;
			end
			ffa_pkg::ST_A_RS:  if (step_done) state_d = ffa_pkg::ST_A_RN;
			ffa_pkg::ST_A_RN:  if (step_done) state_d = ffa_pkg::ST_A_CHK;
			ffa_pkg::ST_A_CHK: begin
				if (size_q <= fs_q)
					state_d = ffa_pkg::ST_A_WN4;
				else if (fn_q == 32'd0 || k_q >= limit_q)
					state_d = ffa_pkg::ST_RESP;
				else if (size_q == fs_q + 32'd8)
					state_d = ffa_pkg::ST_A_LINK;
				else
					state_d = ffa_pkg::ST_A_RS;
			end
			ffa_pkg::ST_A_WN4:  if (step_done) state_d = ffa_pkg::ST_A_WN0;
			ffa_pkg::ST_A_WN0:  if (step_done) state_d = ffa_pkg::ST_A_LINK;
			ffa_pkg::ST_A_LINK: if (step_done) state_d = ffa_pkg::ST_M_RS;
			ffa_pkg::ST_A_WF:   if (step_done) state_d = ffa_pkg::ST_RESP;
			ffa_pkg::ST_F_RS:   if (step_done) state_d = ffa_pkg::ST_F_WS;
			ffa_pkg::ST_F_WS:   if (step_done) state_d = ffa_pkg::ST_F_CMP;
			ffa_pkg::ST_F_CMP:
				state_d = (off_q > head_q) ? ffa_pkg::ST_F_RN : ffa_pkg::ST_F_WH;
			ffa_pkg::ST_F_RN:   if (step_done) state_d = ffa_pkg::ST_F_WCHK;
			ffa_pkg::ST_F_WCHK: begin
				if (fn_q == 32'd0 || fn_q > off_q || k_q >= limit_q)
					state_d = ffa_pkg::ST_F_WO;
				else
					state_d = ffa_pkg::ST_F_RN;
			end
			ffa_pkg::ST_F_WO:   if (step_done) state_d = ffa_pkg::ST_F_WF;
			ffa_pkg::ST_F_WF:   if (step_done) state_d = ffa_pkg::ST_M_RS;
			ffa_pkg::ST_F_M2:   state_d = ffa_pkg::ST_M_RS;
			ffa_pkg::ST_F_WH:   if (step_done) state_d = ffa_pkg::ST_M_RS;
			ffa_pkg::ST_M_RS:   if (step_done) state_d = ffa_pkg::ST_M_RN;
			ffa_pkg::ST_M_RN:   if (step_done) state_d = ffa_pkg::ST_M_CHK;
			ffa_pkg::ST_M_CHK: begin
				if (mf_q + 32'd8 + s_q == n_q && mk_q < limit_q)
					state_d = ffa_pkg::ST_M_RNS;
				else
					state_d = ret_q;
			end
			ffa_pkg::ST_M_RNS:  if (step_done) state_d = ffa_pkg::ST_M_RNN;
			ffa_pkg::ST_M_RNN:  if (step_done) state_d = ffa_pkg::ST_M_W4;
			ffa_pkg::ST_M_W4:   if (step_done) state_d = ffa_pkg::ST_M_W0;
			ffa_pkg::ST_M_W0:   if (step_done) state_d = ffa_pkg::ST_M_CHK;
			ffa_pkg::ST_RESP:   if (load_rsp) state_d = ffa_pkg::ST_IDLE;
			default:            state_d = ffa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffa_pkg::ST_INIT_W0;
			ext_q       <= ffa_pkg::EXTENT_RESET;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			head_q      <= 32'd0;
			limit_q     <= 17'd0;
			ret_q       <= ffa_pkg::ST_RESP;
		end else begin
			state_q <= state_d;
			if (state_q == ffa_pkg::ST_IDLE && cfg_we)
				ext_q <= cfg_wdata;
			// hold the pending flag across a memory access
			if (mem_start)
				pend_q <= 1'b1;
			else if (mem_done)
				pend_q <= 1'b0;
			if (load_rsp)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
			case (state_q)
				ffa_pkg::ST_INIT_W1: begin
					head_q  <= 32'd0;
					limit_q <= ((ext_c - 17'd8) >> 3) + 17'd2;
				end
				ffa_pkg::ST_A_LINK: if (step_done) begin
					if (!has_prev_q)
						head_q <= newf_q;
					ret_q <= ffa_pkg::ST_A_WF;
				end
				ffa_pkg::ST_F_WF: ret_q <= ffa_pkg::ST_F_M2;
				ffa_pkg::ST_F_M2: ret_q <= ffa_pkg::ST_RESP;
				ffa_pkg::ST_F_WH: begin
					ret_q <= ffa_pkg::ST_RESP;
					if (step_done)
						head_q <= off_q;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ffa_pkg::ST_IDLE: if (accept) begin
				op_q       <= opcode;
				f_q        <= head_q;
				k_q        <= 17'd0;
				has_prev_q <= 1'b0;
				fail_q     <= 1'b0;
				off_q      <= {16'd0, block_address - 16'd4};
				if (req_sz < 17'd8)
					size_q <= 32'd8;
				else
					size_q <= {15'd0, req_sz + {16'd0, req_sz[0]}};
			end
			ffa_pkg::ST_A_RS: if (step_done) fs_q <= mem_rdata;
			ffa_pkg::ST_A_RN: if (step_done) fn_q <= mem_rdata;
			ffa_pkg::ST_A_CHK: begin
				if (size_q <= fs_q) begin
					newf_q <= f_q + size_q;
				end else if (fn_q == 32'd0 || k_q >= limit_q) begin
					fail_q <= 1'b1;
				end else if (size_q == fs_q + 32'd8) begin
					newf_q <= fn_q;
				end else begin
					prev_q     <= f_q;
					has_prev_q <= 1'b1;
					f_q        <= fn_q;
					k_q        <= k_q + 17'd1;
				end
			end
			ffa_pkg::ST_A_LINK: begin
				mf_q <= newf_q;
				mk_q <= 17'd0;
			end
			ffa_pkg::ST_F_RS: if (step_done) fs_q <= mem_rdata;
			ffa_pkg::ST_F_CMP: begin
				f_q <= head_q;
				k_q <= 17'd0;
			end
			ffa_pkg::ST_F_RN: if (step_done) fn_q <= mem_rdata;
			ffa_pkg::ST_F_WCHK:
				if (!(fn_q == 32'd0 || fn_q > off_q || k_q >= limit_q)) begin
					f_q <= fn_q;
					k_q <= k_q + 17'd1;
				end
			ffa_pkg::ST_F_WF, ffa_pkg::ST_F_WH: begin
				mf_q <= off_q;
				mk_q <= 17'd0;
			end
			ffa_pkg::ST_F_M2: begin
				mf_q <= f_q;
				mk_q <= 17'd0;
			end
			ffa_pkg::ST_M_RS:  if (step_done) s_q <= mem_rdata;
			ffa_pkg::ST_M_RN:  if (step_done) n_q <= mem_rdata;
			ffa_pkg::ST_M_RNS: if (step_done) ns_q <= mem_rdata;
			ffa_pkg::ST_M_RNN: if (step_done) nn_q <= mem_rdata;
			ffa_pkg::ST_M_W0: if (step_done) begin
				s_q  <= merged;
				n_q  <= nn_q;
				mk_q <= mk_q + 17'd1;
			end
			default: ;
		endcase
		// drop the payload into the output register when it frees
		if (load_rsp) begin
			status_q <= fail_q ? ffa_pkg::STATUS_FAIL : ffa_pkg::STATUS_DONE;
			if (fail_q || op_q == ffa_pkg::OP_FREE)
				address_q <= 16'd0;
			else
				address_q <= f_q[15:0] + 16'd4;
		end
	end

	ffa_mem #(.HEAP_BYTES(HEAP_BYTES)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mem_start),
		.req    (mreq),
		.busy   (mem_busy),
		.done   (mem_done),
		.rdata  (mem_rdata)
	);

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign address   = address_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_start |-> !mem_busy) else $error("memory access started while busy");
	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ffa_pkg::ST_RESP))
		else $error("response raised outside response step");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffa_pkg::ST_A_RS || state_q == ffa_pkg::ST_F_RN) |-> k_q <= limit_q)
		else $error("list walk exceeded step limit");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!req_stall |-> state_q == ffa_pkg::ST_IDLE)
		else $error("request taken while busy");

endmodule
`default_nettype wire

>>> test/ffa_checker.sv
`default_nettype none
module ffa_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [16:0] cfg_wdata,
	input  wire logic        req_valid,
	input  wire logic        req_stall,
	input  wire logic        opcode,
	input  wire logic [15:0] request_bytes,
	input  wire logic [15:0] block_address,
	input  wire logic        rsp_valid,
	input  wire logic        rsp_stall,
	input  wire logic        status,
	input  wire logic [15:0] address,
	output int               mismatches,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HEAP_SZ = ffa_pkg::HEAP_BYTES_DEF;

	typedef struct packed {
		logic        status;
		logic [15:0] address;
	} outcome_t;

	logic [7:0]  heap [0:HEAP_SZ-1];
	logic [31:0] head;
	logic [31:0] walk_limit;
	outcome_t    outcomes_due [$];

	function automatic logic [31:0] peek32(logic [31:0] a);
		logic [31:0] v;
		v = '0;
		for (int i = 3; i >= 0; i--)
			v = {v[23:0], heap[(a + i) % HEAP_SZ]};
		return v;
	endfunction

	function automatic void poke32(logic [31:0] a, logic [31:0] v);
		for (int i = 0; i < 4; i++)
			heap[(a + i) % HEAP_SZ] = v[8*i +: 8];
	endfunction

	function automatic void rebuild_heap(logic [16:0] ext);
		logic [31:0] e;
		e = {15'd0, ext};
		if (e < 16) e = 16;
		if (e > HEAP_SZ) e = HEAP_SZ;
		for (int i = 0; i < HEAP_SZ; i++) heap[i] = '0;
		head = 0;
		poke32(0, e - 8);
		poke32(4, 0);
		walk_limit = (e - 8) / 8 + 2;
	endfunction

	// absorb each node that starts right where this one ends, up to the walk limit
	function automatic void coalesce(logic [31:0] off);
		logic [31:0] s, n, ns, nn, k;
		s = peek32(off);
		n = peek32(off + 4);
		k = 0;
		while (off + 8 + s == n && k < walk_limit) begin
			ns = peek32(n);
			nn = peek32(n + 4);
			s = s + ns + 8;
			poke32(off + 4, nn);
			poke32(off, s);
			n = nn;
			k++;
		end
	endfunction

	function automatic outcome_t allocate(logic [15:0] nbytes);
		logic [31:0] need, f, prev, newf, fs, fn, k;
		bit has_prev, exact;
		outcome_t r;
		need = {16'd0, nbytes} + 32'd4;
		f = head; prev = 0; newf = 0; k = 0;
		has_prev = 0; exact = 0;
		if (need < 8) need = 8;
		else if (need[0]) need++;
		forever begin
			fs = peek32(f);
			fn = peek32(f + 4);
			if (need <= fs) break;
			if (fn == 0 || k >= walk_limit) begin
				r.status = ffa_pkg::STATUS_FAIL;
				r.address = '0;
				return r;
			end
			if (need == fs + 8) begin
				newf = fn;
				exact = 1;
				break;
			end
			prev = f;
			has_prev = 1;
			f = fn;
			k++;
		end
		if (!exact) begin
			newf = f + need;
			poke32(newf + 4, fn);
			poke32(newf, fs - need);
		end
		if (has_prev) poke32(prev + 4, newf);
		else head = newf;
		coalesce(newf);
		poke32(f, need);
		r.status = ffa_pkg::STATUS_DONE;
		r.address = f[15:0] + 16'd4;
		return r;
	endfunction

	function automatic void release_block(logic [15:0] baddr);
		logic [31:0] off, f, n, k;
		off = {16'd0, baddr - 16'd4};
		poke32(off, peek32(off) - 8);
		if (off > head) begin
			f = head;
			k = 0;
			forever begin
				n = peek32(f + 4);
				if (n == 0 || n > off || k >= walk_limit) break;
				f = n;
				k++;
			end
			poke32(off + 4, n);
			poke32(f + 4, off);
			coalesce(off);
			coalesce(f);
		end else begin
			poke32(off + 4, head);
			head = off;
			coalesce(off);
		end
	endfunction

	initial begin
		mismatches = 0;
		rebuild_heap(ffa_pkg::EXTENT_RESET);
	end

	assign outstanding = outcomes_due.size();

	always @(posedge clk or negedge arst_n) begin
		outcome_t want, got;
		if (!arst_n) begin
			outcomes_due.delete();
			rebuild_heap(ffa_pkg::EXTENT_RESET);
		end else begin
			if (cfg_we)
				rebuild_heap(cfg_wdata);
			if (req_valid && !req_stall) begin
				if (opcode == ffa_pkg::OP_ALLOC) begin
					outcomes_due.push_back(allocate(request_bytes));
				end else begin
					release_block(block_address);
					want.status = ffa_pkg::STATUS_DONE;
					want.address = '0;
					outcomes_due.push_back(want);
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (outcomes_due.size() == 0) begin
					$error("unexpected response: status %0d address %0d", status, address);
					mismatches <= mismatches + 1;
				end else begin
					want = outcomes_due.pop_front();
					got.status = status;
					got.address = address;
					if (got.status !== want.status)
						$error("status: expected %0d actual %0d", want.status, got.status);
					if (got.address !== want.address)
						$error("address: expected %0d actual %0d", want.address, got.address);
					if (got !== want) mismatches <= mismatches + 1;
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> test/first_fit_heap_allocator_top_tb.sv
`default_nettype none
module first_fit_heap_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 4000000;

	logic        clk, arst_n;
	logic        cfg_we;
	logic [16:0] cfg_wdata;
	logic        req_valid, req_stall, opcode;
	logic [15:0] request_bytes, block_address;
	logic        rsp_valid, rsp_stall, status;
	logic [15:0] address;
	int          mismatches, outstanding;
	longint      cycles;
	int          sent;          // requests accepted so far, steers idling
	logic [15:0] live_blocks [$];  // payload addresses handed out and not yet freed

	first_fit_heap_allocator_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_stall(req_stall),
		.opcode(opcode), .request_bytes(request_bytes), .block_address(block_address),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .address(address)
	);

	ffa_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_stall(req_stall),
		.opcode(opcode), .request_bytes(request_bytes), .block_address(block_address),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .address(address),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// track live blocks from successful allocations so frees only ever
	// touch heap bytes that have been written
	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall && status == ffa_pkg::STATUS_DONE
				&& address != 0)
			live_blocks.push_back(address);

	// receiver: stall about 11% of the time, but hold a quiet stretch
	always @(negedge clk)
		if (sent >= 700 && sent < 1000) rsp_stall <= 1'b0;
		else rsp_stall <= ($urandom_range(0, 99) < 11);

	// present one request and hold it until it is taken
	task automatic push_request(logic op, logic [15:0] nbytes, logic [15:0] baddr);
		@(negedge clk);
		if (!(sent >= 700 && sent < 1000))
			while ($urandom_range(0, 99) < 11) @(negedge clk);
		opcode <= op;
		request_bytes <= nbytes;
		block_address <= baddr;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		sent++;
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	task automatic alloc_bytes(logic [15:0] nbytes);
		push_request(ffa_pkg::OP_ALLOC, nbytes, 16'($urandom));
	endtask

	task automatic free_live(int idx);
		logic [15:0] a;
		a = live_blocks[idx];
		live_blocks.delete(idx);
		push_request(ffa_pkg::OP_FREE, 16'($urandom), a);
	endtask

	// wait for every response, then let the sequencer settle
	task automatic drain;
		while (outstanding != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_extent(logic [16:0] ext);
		drain();
		live_blocks.delete();
		cfg_wdata <= ext;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		repeat (20) @(negedge clk);
	endtask

	// mostly small requests keep the free list short; a few large ones fail
	task automatic random_traffic(int n);
		int pick;
		logic [15:0] nb;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (live_blocks.size() != 0 && pick < 45) begin
				free_live($urandom_range(0, live_blocks.size() - 1));
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 70) nb = 16'($urandom_range(0, 64));
				else if (pick < 92) nb = 16'($urandom_range(0, 1024));
				else nb = 16'($urandom);
				alloc_bytes(nb);
			end
			// pause once until the block has answered everything
			if (i == n / 2 && sent < 400) drain();
		end
	endtask

	initial begin
		logic [16:0] extents [6];
		cycles = 0;
		sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		opcode = ffa_pkg::OP_ALLOC;
		request_bytes = '0;
		block_address = '0;
		rsp_stall = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: smallest requests raised to the minimum size, oversize failure,
		// then three equal blocks to set up an exact fit
		alloc_bytes(16'd0);
		alloc_bytes(16'd1);
		alloc_bytes(16'hFFFF);
		alloc_bytes(16'd100);
		alloc_bytes(16'd100);
		alloc_bytes(16'd100);
		drain();
		free_live(3);             // middle block becomes a non-last node
		alloc_bytes(16'd100);     // padded size equals node size plus header
		alloc_bytes(16'd7);
		drain();
		free_live(0);             // insert at the list head
		free_live(live_blocks.size() - 1);
		free_live(1);
		alloc_bytes(16'd65000);
		alloc_bytes(16'd65400);
		drain();
		while (live_blocks.size() != 0) free_live(0);
		alloc_bytes(16'd65524);   // whole heap in one block
		alloc_bytes(16'd0);       // nothing left
		drain();
		while (live_blocks.size() != 0) free_live(0);

		random_traffic(520);

		// extent extremes and clamping, then a random one and the reset value
		extents[0] = 17'd0;
		extents[1] = 17'd16;
		extents[2] = 17'h1FFFF;
		extents[3] = 17'd200;
		extents[4] = 17'($urandom_range(16, 65536));
		extents[5] = ffa_pkg::EXTENT_RESET;
		foreach (extents[i]) begin
			set_extent(extents[i]);
			random_traffic(i < 2 ? 40 : 280);
		end

		drain();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
